// File: rtl/bpc_pkg.sv
// Package for the button press classifier: state encoding, configuration
// and result structs, register indexes and reset values.
// No dependencies; every other file of the block imports it.
package bpc_pkg;

	// Configuration register indexes, as seen on the write port.
	typedef enum logic [2:0] {
		CFG_ACTIVE_LEVEL     = 3'd0,
		CFG_DEBOUNCE_TIME    = 3'd1,
		CFG_LONG_PRESS_TIME  = 3'd2,
		CFG_POWER_OFF_TIME   = 3'd3,
		CFG_POWER_OFF_ENABLE = 3'd4
	} cfg_idx_t;

	localparam logic        RST_ACTIVE_LEVEL     = 1'b0;
	localparam logic [31:0] RST_DEBOUNCE_TIME    = 32'd50;
	localparam logic [31:0] RST_LONG_PRESS_TIME  = 32'd1000;
	localparam logic [31:0] RST_POWER_OFF_TIME   = 32'd3000;
	localparam logic        RST_POWER_OFF_ENABLE = 1'b0;

	// External state codes reported on state_code.
	localparam logic [2:0] CODE_RELEASED    = 3'd0;
	localparam logic [2:0] CODE_DEBOUNCING  = 3'd1;
	localparam logic [2:0] CODE_PRESSED     = 3'd2;
	localparam logic [2:0] CODE_LONG        = 3'd3;
	localparam logic [2:0] CODE_POWEROFF    = 3'd4;
	localparam logic [2:0] CODE_OFFIDLE     = 3'd5;
	localparam logic [2:0] CODE_OFFWAKE     = 3'd6;
	localparam logic [2:0] CODE_RELDEBOUNCE = 3'd7;

	// Internal one-hot state encoding.
	typedef enum logic [7:0] {
		ST_RELEASED    = 8'b0000_0001,
		ST_DEBOUNCING  = 8'b0000_0010,
		ST_PRESSED     = 8'b0000_0100,
		ST_LONG        = 8'b0000_1000,
		ST_POWEROFF    = 8'b0001_0000,
		ST_OFFIDLE     = 8'b0010_0000,
		ST_OFFWAKE     = 8'b0100_0000,
		ST_RELDEBOUNCE = 8'b1000_0000
	} state_t;

	// Register values the core uses, plus the power-off arming and window.
	typedef struct packed {
		logic        active_level;
		logic [31:0] debounce_time;
		logic [31:0] long_press_time;
		logic        po_armed;
		logic [31:0] po_window;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic        press_event;
		logic        long_press_event;
		logic        power_off_event;
		logic        wake_event;
		logic        short_press_event;
		logic        release_event;
		logic        is_pressed;
		logic [2:0]  state_code;
		logic [31:0] held_time;
	} res_t;

	function automatic logic [2:0] state_code_of(state_t st);
		logic [2:0] code;
		unique case (st)
			ST_RELEASED:    code = CODE_RELEASED;
			ST_DEBOUNCING:  code = CODE_DEBOUNCING;
			ST_PRESSED:     code = CODE_PRESSED;
			ST_LONG:        code = CODE_LONG;
			ST_POWEROFF:    code = CODE_POWEROFF;
			ST_OFFIDLE:     code = CODE_OFFIDLE;
			ST_OFFWAKE:     code = CODE_OFFWAKE;
			ST_RELDEBOUNCE: code = CODE_RELDEBOUNCE;
			default:        code = CODE_RELEASED;
		endcase
		return code;
	endfunction

endpackage

// File: rtl/bpc_cfg.sv
// Configuration register file for the button press classifier.
// Holds the five writable registers and derives the power-off window.
// Depends on bpc_pkg.
module bpc_cfg
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	logic        active_level_q;
	logic [31:0] debounce_time_q;
	logic [31:0] long_press_time_q;
	logic [31:0] power_off_time_q;
	logic        power_off_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_level_q     <= RST_ACTIVE_LEVEL;
			debounce_time_q    <= RST_DEBOUNCE_TIME;
			long_press_time_q  <= RST_LONG_PRESS_TIME;
			power_off_time_q   <= RST_POWER_OFF_TIME;
			power_off_enable_q <= RST_POWER_OFF_ENABLE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVE_LEVEL:     active_level_q     <= cfg_data[0];
				CFG_DEBOUNCE_TIME:    debounce_time_q    <= cfg_data;
				CFG_LONG_PRESS_TIME:  long_press_time_q  <= cfg_data;
				CFG_POWER_OFF_TIME:   power_off_time_q   <= cfg_data;
				CFG_POWER_OFF_ENABLE: power_off_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The long-press state only times out into power-off when the total hold
	// is strictly longer than the long-press threshold.
	always_comb begin
		cfg.active_level    = active_level_q;
		cfg.debounce_time   = debounce_time_q;
		cfg.long_press_time = long_press_time_q;
		cfg.po_armed        = power_off_enable_q && (power_off_time_q > long_press_time_q);
		cfg.po_window       = power_off_time_q - long_press_time_q;
	end

endmodule

// File: rtl/bpc_core.sv
// State machine of the button press classifier: state registers and the
// combinational next-state and result logic for one pin sample.
// Depends on bpc_pkg.
module bpc_core
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        pin_level,
	input  logic [31:0] now_ms,
	input  cfg_t        cfg,
	output res_t        res
);

	state_t      state_q, state_d;
	logic [31:0] entry_q, entry_d;
	logic [31:0] change_q, change_d;
	logic        was_long_q, was_long_d;
	logic        wake_seen_q, wake_seen_d;

	logic        raw;
	logic [31:0] in_state;
	logic [31:0] since_change;
	logic        debounced;

	assign raw          = (pin_level == cfg.active_level);
	assign in_state     = now_ms - entry_q;
	assign since_change = now_ms - change_q;
	assign debounced    = (since_change >= cfg.debounce_time);

	always_comb begin
		state_d     = state_q;
		change_d    = change_q;
		was_long_d  = was_long_q;
		wake_seen_d = wake_seen_q;
		res         = '0;
		unique case (state_q)
			ST_RELEASED: begin
				if (raw) begin
					was_long_d = 1'b0;
					change_d   = now_ms;
					state_d    = ST_DEBOUNCING;
				end
			end
			ST_DEBOUNCING: begin
				if (!raw) begin
					state_d = ST_RELEASED;
				end else if (debounced) begin
					state_d         = ST_PRESSED;
					res.press_event = 1'b1;
				end
			end
			ST_PRESSED: begin
				if (!raw) begin
					change_d = now_ms;
					state_d  = ST_RELDEBOUNCE;
				end else if (in_state >= cfg.long_press_time) begin
					was_long_d           = 1'b1;
					state_d              = ST_LONG;
					res.long_press_event = 1'b1;
				end
			end
			ST_LONG: begin
				if (!raw) begin
					change_d = now_ms;
					state_d  = ST_RELDEBOUNCE;
				end else if (cfg.po_armed && (in_state >= cfg.po_window)) begin
					state_d             = ST_POWEROFF;
					res.power_off_event = 1'b1;
				end
			end
			ST_POWEROFF: begin
				if (!raw) begin
					state_d = ST_OFFIDLE;
				end
			end
			ST_OFFIDLE: begin
				// The first pressed sample only stamps the time of the edge.
				if (!raw) begin
					wake_seen_d = 1'b0;
				end else if (!wake_seen_q) begin
					wake_seen_d = 1'b1;
					change_d    = now_ms;
				end else if (debounced) begin
					wake_seen_d    = 1'b0;
					res.wake_event = 1'b1;
					state_d        = ST_OFFWAKE;
				end
			end
			ST_OFFWAKE: begin
				if (!raw) begin
					state_d = ST_RELEASED;
				end
			end
			ST_RELDEBOUNCE: begin
				// A bounce back returns to where the press was before.
				if (raw) begin
					state_d = was_long_q ? ST_LONG : ST_PRESSED;
				end else if (debounced) begin
					state_d               = ST_RELEASED;
					res.short_press_event = !was_long_q;
					res.release_event     = 1'b1;
				end
			end
			default: begin
				state_d = ST_RELEASED;
			end
		endcase

		entry_d = (state_d != state_q) ? now_ms : entry_q;

		res.is_pressed = (state_d == ST_PRESSED) || (state_d == ST_LONG) ||
			(state_d == ST_POWEROFF) || (state_d == ST_OFFWAKE);
		res.state_code = state_code_of(state_d);
		res.held_time  = now_ms - entry_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RELEASED;
			entry_q     <= '0;
			change_q    <= '0;
			was_long_q  <= 1'b0;
			wake_seen_q <= 1'b0;
		end else if (step) begin
			state_q     <= state_d;
			entry_q     <= entry_d;
			change_q    <= change_d;
			was_long_q  <= was_long_d;
			wake_seen_q <= wake_seen_d;
		end
	end

endmodule

// File: rtl/button_press_classifier.sv
// Top level of the button press classifier: input register, state machine
// core, configuration registers and result register.
// Depends on bpc_pkg, bpc_cfg and bpc_core.
//
// The block takes one transaction per clock on the input channel while results
// drain, each a raw pin sample with a wrapping 32-bit millisecond timestamp, and
// returns exactly one result transaction for it. A sample is captured in the
// input register on acceptance and is classified there by the state machine.
// Its result is loaded into the output register when the sample moves on, held
// back while the result register is full and not being drained; out_valid then
// rises and the result is taken when the output side is ready. Input and output
// are pipelined: a new sample is taken in every cycle as long as the result
// register is empty or being emptied in the same cycle, and the sustained rate
// is one transaction per clock. That rate is set by the state update in the
// core, which advances the debouncer by exactly one sample per clock in which
// a sample moves on. Events (press, long press, power off, wake, short press,
// release) are flags inside one result; is_pressed, state_code and held_time
// describe the state after the sample. All elapsed times are wrapping 32-bit
// differences, so timestamps may roll over freely. Configuration registers are
// written through a plain write port (index 0 active level, 1 debounce time,
// 2 long-press time, 3 power-off time, 4 power-off enable) and must only be
// changed while no transaction is in flight; writes to other indexes are
// ignored. After reset the machine is in the released state with its state
// entry time at zero.
module button_press_classifier
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        pin_level,
	input  logic [31:0] now_ms,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        press_event,
	output logic        long_press_event,
	output logic        power_off_event,
	output logic        wake_event,
	output logic        short_press_event,
	output logic        release_event,
	output logic        is_pressed,
	output logic [2:0]  state_code,
	output logic [31:0] held_time
);

	cfg_t        cfg;
	res_t        res;
	res_t        res_s2;
	logic        valid_s1;
	logic        pin_level_s1;
	logic [31:0] now_ms_s1;
	logic        valid_s2;
	logic        advance;

	// The sample in the input register moves on when the result register is
	// free or is being drained in this cycle.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bpc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.pin_level (pin_level_s1),
		.now_ms    (now_ms_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pin_level_s1 <= pin_level;
			now_ms_s1    <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid         = valid_s2;
	assign press_event       = res_s2.press_event;
	assign long_press_event  = res_s2.long_press_event;
	assign power_off_event   = res_s2.power_off_event;
	assign wake_event        = res_s2.wake_event;
	assign short_press_event = res_s2.short_press_event;
	assign release_event     = res_s2.release_event;
	assign is_pressed        = res_s2.is_pressed;
	assign state_code        = res_s2.state_code;
	assign held_time         = res_s2.held_time;

	// At most one distinct event per result; a short press always comes with
	// its release.
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({press_event, long_press_event, power_off_event,
			wake_event, release_event}))
		else $error("more than one event in one result");

	a_short_has_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && short_press_event) |-> release_event)
		else $error("short press without release");

	// Every event comes with a state change, so the hold time restarts.
	a_event_restarts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (press_event || long_press_event || power_off_event ||
			wake_event || release_event)) |-> (held_time == '0))
		else $error("event without a fresh state entry");

	a_press_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && press_event) |-> (is_pressed && (state_code == CODE_PRESSED)))
		else $error("press event outside the pressed state");

	// A sample is only taken into a full input register when it moves on.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && valid_s1) |-> advance)
		else $error("input register overwritten");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for button_press_classifier: drives pin samples with
// timestamps, predicts every result with a cycle-free model of the debouncer.
// Depends on bpc_pkg and the button_press_classifier RTL.
`timescale 1ns / 100ps

module tb_top
	import bpc_pkg::*;
();

	// Quiet clocks after the last result is checked, so that nothing is still
	// moving before registers change.
	localparam int unsigned SETTLE_CYCLES = 4;
	// Generous ceiling on the run length, far above the slowest legal run.
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Largest hold we ask for, kept clear of the 32-bit wrap.
	localparam longint HOLD_CLIP = 64'h0000_0000_FFFF_FF00;
	// Write-port indexes past the last register; writes there must be ignored.
	localparam logic [2:0] SPARE_IDX_LO = 3'(CFG_POWER_OFF_ENABLE) + 3'd1;
	localparam logic [2:0] SPARE_IDX_HI = '1;

	// One pin sample waiting to be sent. A sample marked drain_first is held
	// back until every result already in flight has been checked.
	typedef struct {
		logic        pin;
		logic [31:0] ms;
		bit          drain_first;
	} sample_t;

	// What the block should report for one sample.
	typedef struct packed {
		logic        press_ev;
		logic        long_ev;
		logic        off_ev;
		logic        wake_ev;
		logic        short_ev;
		logic        release_ev;
		logic        pressed;
		logic [2:0]  code;
		logic [31:0] held;
	} outcome_t;

	// Clock, reset and every block input start at known values.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        pin_level = 1'b0;
	logic [31:0] now_ms = '0;
	logic        out_ready = 1'b0;

	logic        in_ready;
	logic        out_valid;
	logic        press_event;
	logic        long_press_event;
	logic        power_off_event;
	logic        wake_event;
	logic        short_press_event;
	logic        release_event;
	logic        is_pressed;
	logic [2:0]  state_code;
	logic [31:0] held_time;

	button_press_classifier dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.pin_level        (pin_level),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.press_event      (press_event),
		.long_press_event (long_press_event),
		.power_off_event  (power_off_event),
		.wake_event       (wake_event),
		.short_press_event(short_press_event),
		.release_event    (release_event),
		.is_pressed       (is_pressed),
		.state_code       (state_code),
		.held_time        (held_time)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Samples not yet offered to the block, and outcomes of samples that the
	// block has taken but whose result transaction has not been checked yet.
	sample_t  pending_q[$];
	outcome_t outcome_q[$];

	int unsigned fail_count = 0;
	int unsigned samples_queued = 0;
	int unsigned samples_taken = 0;
	int unsigned results_checked = 0;
	int unsigned settings_used = 0;
	int unsigned cycle_count = 0;
	int unsigned event_tally[6];
	logic [31:0] ms_clock = '0;
	// When set, neither side idles, so long back-to-back stretches occur.
	bit          quiet = 1'b0;

	// Shadow of the configuration registers, starting at their reset values.
	logic        m_active = RST_ACTIVE_LEVEL;
	logic [31:0] m_debounce = RST_DEBOUNCE_TIME;
	logic [31:0] m_long = RST_LONG_PRESS_TIME;
	logic [31:0] m_po_time = RST_POWER_OFF_TIME;
	logic        m_po_en = RST_POWER_OFF_ENABLE;

	// Shadow of the debouncer state. The state is kept as its external code.
	logic [2:0]  btn_state = CODE_RELEASED;
	logic [31:0] entry_ms = '0;
	logic [31:0] change_ms = '0;
	logic        was_long = 1'b0;
	logic        wake_armed = 1'b0;

	function automatic void move_to(input logic [2:0] next, input logic [31:0] now);
		btn_state = next;
		entry_ms = now;
	endfunction

	// Advances the shadow debouncer by one sample and returns the result the
	// block must give for it. Elapsed times are taken before any state change
	// and wrap modulo 2^32, exactly as the hardware subtracts them.
	function automatic outcome_t classify(input logic pin, input logic [31:0] now);
		outcome_t    r;
		logic        hit;
		logic [31:0] in_state;
		logic [31:0] since_change;
		r = '0;
		hit = (pin == m_active);
		in_state = now - entry_ms;
		since_change = now - change_ms;
		case (btn_state)
			CODE_RELEASED: begin
				if (hit) begin
					was_long = 1'b0;
					change_ms = now;
					move_to(CODE_DEBOUNCING, now);
				end
			end
			CODE_DEBOUNCING: begin
				if (!hit) begin
					move_to(CODE_RELEASED, now);
				end else if (since_change >= m_debounce) begin
					move_to(CODE_PRESSED, now);
					r.press_ev = 1'b1;
				end
			end
			CODE_PRESSED: begin
				if (!hit) begin
					change_ms = now;
					move_to(CODE_RELDEBOUNCE, now);
				end else if (in_state >= m_long) begin
					was_long = 1'b1;
					move_to(CODE_LONG, now);
					r.long_ev = 1'b1;
				end
			end
			CODE_LONG: begin
				// The power-off window counts from the long-press point, so it
				// only exists when the total hold exceeds the long-press time.
				if (!hit) begin
					change_ms = now;
					move_to(CODE_RELDEBOUNCE, now);
				end else if (m_po_en && (m_po_time > m_long) &&
						(in_state >= m_po_time - m_long)) begin
					move_to(CODE_POWEROFF, now);
					r.off_ev = 1'b1;
				end
			end
			CODE_POWEROFF: begin
				if (!hit)
					move_to(CODE_OFFIDLE, now);
			end
			CODE_OFFIDLE: begin
				// The first pressed sample only arms the wake debounce.
				if (hit) begin
					if (!wake_armed) begin
						wake_armed = 1'b1;
						change_ms = now;
					end else if (since_change >= m_debounce) begin
						wake_armed = 1'b0;
						r.wake_ev = 1'b1;
						move_to(CODE_OFFWAKE, now);
					end
				end else begin
					wake_armed = 1'b0;
				end
			end
			CODE_OFFWAKE: begin
				if (!hit)
					move_to(CODE_RELEASED, now);
			end
			CODE_RELDEBOUNCE: begin
				// A bounce back resumes the press it came from.
				if (hit) begin
					move_to(was_long ? CODE_LONG : CODE_PRESSED, now);
				end else if (since_change >= m_debounce) begin
					move_to(CODE_RELEASED, now);
					r.short_ev = !was_long;
					r.release_ev = 1'b1;
				end
			end
			default: ;
		endcase
		r.pressed = (btn_state == CODE_PRESSED) || (btn_state == CODE_LONG) ||
			(btn_state == CODE_POWEROFF) || (btn_state == CODE_OFFWAKE);
		r.code = btn_state;
		r.held = now - entry_ms;
		return r;
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Input side: offers the oldest pending sample, holds it steady until the
	// transaction completes, and books its predicted outcome on acceptance.
	always @(posedge clk or negedge arst_n) begin : sample_driver
		logic        fire;
		int unsigned send_wait;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_wait = 0;
		end else begin
			if (in_valid && in_ready) begin
				outcome_q.push_back(classify(pin_level, now_ms));
				samples_taken++;
			end
			if (!in_valid || in_ready) begin
				fire = 1'b0;
				if (send_wait != 0)
					send_wait--;
				else if (pending_q.size() != 0 &&
						!(pending_q[0].drain_first && outcome_q.size() != 0))
					fire = 1'b1;
				if (fire) begin
					in_valid <= 1'b1;
					pin_level <= pending_q[0].pin;
					now_ms <= pending_q[0].ms;
					void'(pending_q.pop_front());
					send_wait = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: stalls at random and checks every result transaction
	// against the oldest booked outcome, field by field.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		outcome_t    want;
		int unsigned recv_wait;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					$error("result transaction arrived with no sample outstanding");
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					check_field("press_event", 32'(want.press_ev), 32'(press_event));
					check_field("long_press_event", 32'(want.long_ev),
						32'(long_press_event));
					check_field("power_off_event", 32'(want.off_ev),
						32'(power_off_event));
					check_field("wake_event", 32'(want.wake_ev), 32'(wake_event));
					check_field("short_press_event", 32'(want.short_ev),
						32'(short_press_event));
					check_field("release_event", 32'(want.release_ev),
						32'(release_event));
					check_field("is_pressed", 32'(want.pressed), 32'(is_pressed));
					check_field("state_code", 32'(want.code), 32'(state_code));
					check_field("held_time", want.held, held_time);
					event_tally[0] += 32'(want.press_ev);
					event_tally[1] += 32'(want.long_ev);
					event_tally[2] += 32'(want.off_ev);
					event_tally[3] += 32'(want.wake_ev);
					event_tally[4] += 32'(want.short_ev);
					event_tally[5] += 32'(want.release_ev);
					results_checked++;
				end
			end
			if (recv_wait != 0) begin
				recv_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				recv_wait = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic void queue_sample_at(input logic pin, input logic [31:0] ms,
			input bit drain_first);
		sample_t s;
		s.pin = pin;
		s.ms = ms;
		s.drain_first = drain_first;
		ms_clock = ms;
		pending_q.push_back(s);
		samples_queued++;
	endfunction

	function automatic void queue_sample(input logic pin, input int unsigned adv,
			input bit drain_first);
		queue_sample_at(pin, ms_clock + adv, drain_first);
	endfunction

	// Waits until nothing is queued, offered or outstanding, then lets the
	// pipeline settle. The queues are looked at on the falling edge, when the
	// driver and the monitor have finished their work for the cycle.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_q.size() != 0 || in_valid || outcome_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	// Writes all five registers back to back. The one-bit registers get
	// random upper data bits, which the block must drop, and one write goes
	// to an unused index, which the block must ignore.
	task automatic apply_settings(input logic act, input logic [31:0] db,
			input logic [31:0] lp, input logic [31:0] po, input logic en);
		logic [31:0] junk;
		junk = $urandom();
		put_reg(CFG_ACTIVE_LEVEL, {junk[31:1], act});
		put_reg(CFG_DEBOUNCE_TIME, db);
		put_reg(CFG_LONG_PRESS_TIME, lp);
		put_reg(CFG_POWER_OFF_TIME, po);
		junk = $urandom();
		put_reg(CFG_POWER_OFF_ENABLE, {junk[31:1], en});
		put_reg(3'($urandom_range(SPARE_IDX_LO, SPARE_IDX_HI)), $urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
		m_active = act;
		m_debounce = db;
		m_long = lp;
		m_po_time = po;
		m_po_en = en;
		settings_used++;
		wait_idle();
	endtask

	// One well-formed button press: optional contact bounce, a steady hold of
	// about hold_ms, an optional bounce back during release, then a release
	// long enough (usually) to pass the debounce time.
	task automatic queue_press(input longint hold_ms, input bit drain_first);
		logic   on_lvl;
		longint held;
		longint stride;
		int unsigned adv;
		on_lvl = m_active;
		queue_sample(on_lvl, $urandom_range(1, 5), drain_first);
		repeat ($urandom_range(0, 2)) begin
			queue_sample(!on_lvl, $urandom_range(0, 3), 1'b0);
			queue_sample(on_lvl, $urandom_range(0, 3), 1'b0);
		end
		stride = hold_ms / 6 + 1;
		held = 0;
		while (held <= hold_ms) begin
			adv = $urandom_range(1, 32'(stride));
			queue_sample(on_lvl, adv, 1'b0);
			held += adv;
		end
		if ($urandom_range(0, 2) == 0) begin
			queue_sample(!on_lvl, $urandom_range(0, 3), 1'b0);
			queue_sample(on_lvl, $urandom_range(0, 3), 1'b0);
		end
		stride = longint'(m_debounce) / 3 + 1;
		repeat ($urandom_range(3, 6))
			queue_sample(!on_lvl, $urandom_range(32'(stride / 2), 32'(stride)), 1'b0);
	endtask

	initial begin : stimulus
		logic        act;
		logic        en;
		logic [31:0] db;
		logic [31:0] lp;
		logic [31:0] po;
		longint      base;
		longint      extra;
		longint      hold;
		int unsigned budget;
		int unsigned start;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: pressed is pin low, 50 ms debounce, 1000 ms long
		// press, power-off disabled. Covers a press that bounces, a bounce
		// back during release from both a short and a long press, a long
		// hold that cannot power off, and a clean short press.
		queue_sample_at(1'b1, 32'd0, 1'b0);
		queue_sample_at(1'b0, 32'd10, 1'b0);
		queue_sample_at(1'b0, 32'd59, 1'b0);
		queue_sample_at(1'b0, 32'd60, 1'b0);
		queue_sample_at(1'b1, 32'd100, 1'b0);
		queue_sample_at(1'b0, 32'd120, 1'b0);
		queue_sample_at(1'b0, 32'd1120, 1'b0);
		queue_sample_at(1'b0, 32'd9000, 1'b0);
		queue_sample_at(1'b1, 32'd9001, 1'b0);
		queue_sample_at(1'b0, 32'd9002, 1'b0);
		queue_sample_at(1'b1, 32'd9003, 1'b0);
		queue_sample_at(1'b1, 32'd9053, 1'b0);
		// The sender holds this one back until the pipeline is empty.
		queue_sample_at(1'b0, 32'd9100, 1'b1);
		queue_sample_at(1'b0, 32'd9150, 1'b0);
		queue_sample_at(1'b1, 32'd9200, 1'b0);
		queue_sample_at(1'b1, 32'd9250, 1'b0);
		wait_idle();

		// Active high with zero debounce and long-press times: each stage
		// is taken on the next sample. The hold crosses the timestamp wrap
		// into power-off, then a wake press and a wake release follow.
		apply_settings(1'b1, 32'd0, 32'd0, 32'd5, 1'b1);
		queue_sample_at(1'b1, 32'hFFFF_FFF0, 1'b0);
		queue_sample_at(1'b1, 32'hFFFF_FFF0, 1'b0);
		queue_sample_at(1'b1, 32'hFFFF_FFF1, 1'b0);
		queue_sample_at(1'b1, 32'h0000_0003, 1'b0);
		queue_sample_at(1'b0, 32'h0000_0004, 1'b0);
		queue_sample_at(1'b1, 32'h0000_0005, 1'b0);
		queue_sample_at(1'b1, 32'h0000_0005, 1'b0);
		queue_sample_at(1'b0, 32'hFFFF_FFFF, 1'b0);
		wait_idle();

		// Random part: a handful of register settings, each with a budget of
		// samples made mostly of whole presses and a little raw noise.
		for (int p = 0; p < 6; p++) begin
			act = 1'($urandom_range(0, 1));
			db = $urandom_range(2, 20);
			lp = $urandom_range(40, 150);
			po = lp + $urandom_range(30, 300);
			en = 1'b1;
			budget = 100;
			case (p)
				0: begin
					// Reachable power-off with short times.
					budget = 130;
				end
				1: begin
					// Power-off time not above long press: never powers off.
					po = $urandom_range(0, lp);
				end
				2: begin
					// Zero debounce and long-press times.
					db = '0;
					lp = '0;
					po = $urandom_range(1, 60);
					budget = 90;
				end
				3: begin
					en = 1'b0;
				end
				4: begin
					// Largest times: nothing gets past debouncing.
					db = '1;
					lp = '1;
					po = '1;
					budget = 60;
				end
				default: begin
					budget = 140;
				end
			endcase
			apply_settings(act, db, lp, po, en);
			ms_clock = ($urandom_range(0, 1) == 0) ? $urandom() :
				32'hFFFF_F000 + $urandom_range(0, 32'hF00);
			start = samples_queued;
			while (samples_queued - start < budget) begin
				quiet = ($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 6) == 0) begin
					repeat ($urandom_range(1, 4)) begin
						if ($urandom_range(0, 1) == 0)
							queue_sample_at(1'($urandom_range(0, 1)), $urandom(), 1'b0);
						else
							queue_sample(1'($urandom_range(0, 1)), $urandom_range(0, 20), 1'b0);
					end
				end else begin
					// Aim for a short press, a long press or a power-off hold.
					case ($urandom_range(0, 2))
						0: begin
							base = 0;
							extra = longint'(db) + lp;
						end
						1: begin
							base = longint'(db) + lp;
							extra = (po > lp) ? longint'(po - lp) : 200;
						end
						default: begin
							base = longint'(db) + po;
							extra = 200;
						end
					endcase
					if (extra > HOLD_CLIP)
						extra = HOLD_CLIP;
					hold = base + $urandom_range(0, 32'(extra));
					if (hold > HOLD_CLIP)
						hold = HOLD_CLIP;
					queue_press(hold, $urandom_range(0, 39) == 0);
				end
				// Let the queue drain a little so gaps land on every phase.
				while (pending_q.size() > 40)
					@(posedge clk);
			end
			wait_idle();
			quiet = 1'b0;
		end

		wait_idle();
		$display("Covered %0d samples and %0d checked results under %0d register settings.",
			samples_taken, results_checked, settings_used + 1);
		$display("Events: press %0d, long %0d, power-off %0d, wake %0d, short %0d, release %0d.",
			event_tally[0], event_tally[1], event_tally[2], event_tally[3],
			event_tally[4], event_tally[5]);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
